@@ sv/tdtd_pkg.sv @@
// Package: widths, register indexes and constant tables for the drift time-to-distance core.
package tdtd_pkg;

    localparam int TANH_TABLE_BITS = 8;
    localparam int SQRT_TABLE_BITS = 8;
    localparam int TANH_N          = 1 << TANH_TABLE_BITS;
    localparam int SQRT_N          = 1 << SQRT_TABLE_BITS;
    localparam int TANH_FB         = 19 - TANH_TABLE_BITS;
    localparam int SEC_FB          = 15 - SQRT_TABLE_BITS;
    localparam int TANH_ARG_BITS   = 19;
    localparam int U_W             = 50;
    localparam int TH_W            = 17;
    localparam int SEC_W           = 20;
    localparam int DIST_W          = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [TH_W-1:0] ONE_Q16 = TH_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_VEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_COEFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_DIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SAT     = 3'd4;

    typedef logic [TH_W-1:0]  tanh_tab_t [0:TANH_N];
    typedef logic [SEC_W-1:0] sec_tab_t  [0:SQRT_N];

    // Side data travelling with a word down the back half of the pipe
    typedef struct packed {
        logic             early;
        logic             neg;
        logic [SEC_W-1:0] sec;
    } side_t;

    // Restoring long division, used only while the tables are built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh at 8*i/N in Q1.16, from p_i = exp(-2x) stepped by a series ratio
    function automatic tanh_tab_t build_tanh();
        tanh_tab_t   tab;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] p;
        logic [63:0] k;
        logic [63:0] den;
        logic [63:0] num;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        p    = 64'd1 << 32;
        k    = 64'd1;
        while (term != 64'd0) begin
            term = udiv64(term >> (TANH_TABLE_BITS - 4), k);
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
            k = k + 64'd1;
        end
        for (int i = 0; i <= TANH_N; i++) begin
            den    = (64'd1 << 32) + p;
            num    = ((64'd1 << 32) - p) << 16;
            tab[i] = TH_W'(udiv64(num + (den >> 1), den));
            p      = (p * sum) >> 32;
        end
        return tab;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // sqrt(1 + s^2) in Q.16 at s = 8*i/N
    function automatic sec_tab_t build_sec();
        sec_tab_t    tab;
        logic [63:0] s;
        for (int i = 0; i <= SQRT_N; i++) begin
            s      = 64'(i) << (19 - SQRT_TABLE_BITS);
            tab[i] = SEC_W'(isqrt64((64'd1 << 32) + s * s));
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh();
    localparam sec_tab_t  SEC_TAB  = build_sec();

endpackage

@@ sv/tdtd_tanh_unit.sv @@
// Two-stage interpolated tanh lookup with saturation at and above 8.0.
module tdtd_tanh_unit (
    input  logic                      clk,
    input  logic                      en,
    input  logic [tdtd_pkg::U_W-1:0]  u,
    output logic [tdtd_pkg::TH_W-1:0] th
);
    import tdtd_pkg::*;

    logic                       sat_reg,  sat_next;
    logic [TH_W-1:0]            lo_reg,   lo_next;
    logic [TH_W-1:0]            diff_reg, diff_next;
    logic [TANH_FB-1:0]         frac_reg, frac_next;
    logic [TH_W-1:0]            th_reg,   th_next;
    logic [TANH_TABLE_BITS-1:0] idx;
    logic [TANH_TABLE_BITS:0]   idx_up;
    logic [TH_W+TANH_FB-1:0]    prod;

    always_comb
    begin
        idx       = u[TANH_ARG_BITS-1:TANH_FB];
        idx_up    = {1'b0, idx} + 1'b1;
        sat_next  = |u[U_W-1:TANH_ARG_BITS];
        lo_next   = TANH_TAB[idx];
        diff_next = TANH_TAB[idx_up] - TANH_TAB[idx];
        frac_next = u[TANH_FB-1:0];
    end

    always_comb
    begin
        prod    = diff_reg * frac_reg;
        th_next = sat_reg ? ONE_Q16 : TH_W'(lo_reg + TH_W'(prod >> TANH_FB));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg  <= sat_next;
            lo_reg   <= lo_next;
            diff_reg <= diff_next;
            frac_reg <= frac_next;
            th_reg   <= th_next;
        end
    end

    assign th = th_reg;

endmodule

@@ sv/tanh_drift_time_to_distance_core.sv @@
// Top level: pipelined drift time to distance conversion with a tanh fit.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid / in_ready                       | drift_time, track_slope
//  out     | out_valid / out_ready                     | distance, before_offset
//  cfg     | cfg_wr_en, cfg_index, cfg_data            | one register per write
//
//  Eleven register stages; a word enters every cycle in which the pipe advances.
//  The whole pipe advances together whenever the output register is empty or taken,
//  so a stall freezes every stage and nothing is lost or repeated.
//  Reset clears valid bits and config registers (all zero), not data; no clearing pass.
//  Depth is set by the multiply chain (t^2, c2*t^2, reciprocal, c0, secant)
//  and the two table interpolations.
module tanh_drift_time_to_distance_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              drift_time,
    input  logic signed [15:0]              track_slope,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tdtd_pkg::DIST_W-1:0]     distance,
    output logic                            before_offset,
    input  logic                            cfg_wr_en,
    input  logic [tdtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdtd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tdtd_pkg::*;

    localparam int NSTG = 11;

    // configuration registers
    logic [15:0] t0_reg;
    logic [23:0] vel_reg;
    logic [23:0] c2_reg;
    logic [19:0] c0_reg;
    logic [31:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg  <= '0;
            vel_reg <= '0;
            c2_reg  <= '0;
            c0_reg  <= '0;
            inv_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TIME_OFFSET: t0_reg  <= cfg_data[15:0];
                REG_DRIFT_VEL:   vel_reg <= cfg_data[23:0];
                REG_QUAD_COEFF:  c2_reg  <= cfg_data[23:0];
                REG_SAT_DIST:    c0_reg  <= cfg_data[19:0];
                REG_INV_SAT:     inv_reg <= cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // global advance
    logic            en;
    logic [NSTG:1]   vld_reg;

    assign en       = !vld_reg[NSTG] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-1:1], in_valid};
    end

    // side data, stages 4 to 10
    side_t side_reg [4:10];

    // S1: t = time - t0, |slope|
    logic signed [16:0] t1_reg,  t1_next;
    logic [15:0]        a1_reg,  a1_next;
    logic               b1_reg,  b1_next;

    always_comb
    begin
        t1_next = {drift_time[15], drift_time} - {t0_reg[15], t0_reg};
        b1_next = t1_next[16] || (t1_next == 17'sd0);
        a1_next = track_slope[15] ? 16'(~track_slope + 16'sd1) : 16'(track_slope);
    end

    // S2: t^2, v*t, secant table read
    logic [31:0]             tsq2_reg,  tsq2_next;
    logic [39:0]             vt2_reg,   vt2_next;
    logic [SEC_W-1:0]        slo2_reg,  slo2_next;
    logic [SEC_W-1:0]        sdf2_reg,  sdf2_next;
    logic [SEC_FB-1:0]       sf2_reg,   sf2_next;
    logic                    b2_reg;
    logic [SQRT_TABLE_BITS:0] sidx;

    always_comb
    begin
        tsq2_next = t1_reg[15:0] * t1_reg[15:0];
        vt2_next  = vel_reg * t1_reg[15:0];
        sidx      = a1_reg[15:SEC_FB];
        sf2_next  = a1_reg[SEC_FB-1:0];
        if (sidx >= (SQRT_TABLE_BITS+1)'(SQRT_N))
        begin
            // slope of -8.0: last entry, flat
            slo2_next = SEC_TAB[SQRT_N];
            sdf2_next = '0;
        end
        else
        begin
            slo2_next = SEC_TAB[sidx];
            sdf2_next = SEC_TAB[sidx + 1'b1] - SEC_TAB[sidx];
        end
    end

    // S3: c2*t^2, secant interpolation
    logic signed [56:0]       quad3_reg, quad3_next;
    logic [39:0]              vt3_reg;
    logic [SEC_W-1:0]         sec3_reg,  sec3_next;
    logic                     b3_reg;
    logic [SEC_W+SEC_FB-1:0]  sprod;

    always_comb
    begin
        quad3_next = $signed(c2_reg) * $signed({1'b0, tsq2_reg});
        sprod      = sdf2_reg * sf2_reg;
        sec3_next  = slo2_reg + SEC_W'(sprod >> SEC_FB);
    end

    // S4: argument sum and magnitude
    logic [56:0]        m4_reg, m4_next;
    side_t              side4_next;
    logic signed [56:0] x4;

    always_comb
    begin
        x4         = $signed({9'b0, vt3_reg, 8'b0}) + quad3_reg;
        side4_next = '{early: b3_reg, neg: x4[56], sec: sec3_reg};
        m4_next    = x4[56] ? 57'(-x4) : 57'(x4);
    end

    // S5: |x| * 1/c0 in two halves
    logic [56:0] phi5_reg, phi5_next;
    logic [63:0] plo5_reg, plo5_next;

    always_comb
    begin
        phi5_next = m4_reg[56:32] * inv_reg;
        plo5_next = m4_reg[31:0] * inv_reg;
    end

    // S6: u in Q.16
    logic [U_W-1:0] u6_reg, u6_next;
    logic [57:0]    usum;

    always_comb
    begin
        usum    = {1'b0, phi5_reg} + {26'b0, plo5_reg[63:32]};
        u6_next = usum[57:8];
    end

    // S7, S8: tanh lookup
    logic [TH_W-1:0] th8;

    tdtd_tanh_unit u_tanh (
        .clk (clk),
        .en  (en),
        .u   (u6_reg),
        .th  (th8)
    );

    // S9: c0 * tanh ; S10: times secant
    logic [36:0] cth9_reg, cth9_next;
    logic [56:0] d10_reg,  d10_next;

    always_comb
    begin
        cth9_next = c0_reg * th8;
        d10_next  = cth9_reg * side_reg[9].sec;
    end

    // S11: output register, clamp
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              bo_reg;

    always_comb
    begin
        if (side_reg[10].early || side_reg[10].neg)
            dist_next = '0;
        else if (|d10_reg[56:32+DIST_W])
            dist_next = {DIST_W{1'b1}};
        else
            dist_next = d10_reg[32+DIST_W-1:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg      <= t1_next;
            a1_reg      <= a1_next;
            b1_reg      <= b1_next;
            tsq2_reg    <= tsq2_next;
            vt2_reg     <= vt2_next;
            slo2_reg    <= slo2_next;
            sdf2_reg    <= sdf2_next;
            sf2_reg     <= sf2_next;
            b2_reg      <= b1_reg;
            quad3_reg   <= quad3_next;
            vt3_reg     <= vt2_reg;
            sec3_reg    <= sec3_next;
            b3_reg      <= b2_reg;
            m4_reg      <= m4_next;
            side_reg[4] <= side4_next;
            for (int k = 5; k <= 10; k++)
                side_reg[k] <= side_reg[k-1];
            phi5_reg    <= phi5_next;
            plo5_reg    <= plo5_next;
            u6_reg      <= u6_next;
            cth9_reg    <= cth9_next;
            d10_reg     <= d10_next;
            dist_reg    <= dist_next;
            bo_reg      <= side_reg[10].early;
        end
    end

    assign out_valid     = vld_reg[NSTG];
    assign distance      = dist_reg;
    assign before_offset = bo_reg;

    // checks
    a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && before_offset) |-> (distance == '0))
        else $error("before_offset word with nonzero distance");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipe valid bits moved during a stall");

    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NSTG-1]) |=> out_valid)
        else $error("word lost on entry to output register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output register");

endmodule
